FILE: hdl/hfs_pkg.sv
// ----------------------------------------------------------------------------
// Histogram FIR smoothing package
// Shared widths, function codes, control structs and FSM encoding.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned ProdW   = SampleW + CoefW;
  localparam int unsigned SumW    = 55;

  // Item function codes
  localparam logic FuncCoef   = 1'b0;
  localparam logic FuncSample = 1'b1;

  // Control for every cell of the delay line
  typedef struct packed {
    logic shift;   // window moves one cell towards the head, new count at the tail
    logic rotate;  // window and kernel both circulate, head wraps to the tail
    logic clear;   // zero the window
  } cell_ctrl_t;

  // Control for the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // start a new sum
    logic mul_en;  // head pair is valid this cycle
  } mac_ctrl_t;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRot   = 5'b00010,
    StDrain = 5'b00100,
    StDone  = 5'b01000,
    StFlush = 5'b10000
  } state_e;

endpackage

FILE: hdl/hfs_cell.sv
// ----------------------------------------------------------------------------
// Histogram FIR smoothing cell
// Holds one window count and one kernel tap; loads from its neighbour.
// ----------------------------------------------------------------------------
module hfs_cell
  import hfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic               coef_we_i,
  input  logic [CoefW-1:0]   coef_wdata_i,
  input  logic [SampleW-1:0] win_i,
  input  logic [CoefW-1:0]   coef_i,
  output logic [SampleW-1:0] win_o,
  output logic [CoefW-1:0]   coef_o
);

  logic [SampleW-1:0] win_d, win_q;
  logic [CoefW-1:0]   coef_d, coef_q;

  always_comb begin
    win_d  = win_q;
    coef_d = coef_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.shift || ctrl_i.rotate) begin
      win_d = win_i;
    end
    if (ctrl_i.rotate) begin
      coef_d = coef_i;
    end else if (coef_we_i) begin
      coef_d = coef_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      coef_q <= '0;
    end else begin
      win_q  <= win_d;
      coef_q <= coef_d;
    end
  end

  assign win_o  = win_q;
  assign coef_o = coef_q;

endmodule

FILE: hdl/hfs_mac.sv
// ----------------------------------------------------------------------------
// Histogram FIR smoothing multiply-accumulate
// Registered 32x16 product of the head cell, then a 55-bit accumulate.
// ----------------------------------------------------------------------------
module hfs_mac
  import hfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctrl_t          ctrl_i,
  input  logic [SampleW-1:0] win_i,
  input  logic [CoefW-1:0]   coef_i,
  output logic [SumW-1:0]    acc_o
);

  logic [ProdW-1:0] prod_d, prod_q;
  logic             prod_vld_d, prod_vld_q;
  logic [SumW-1:0]  acc_d, acc_q;

  always_comb begin
    prod_d     = ProdW'(win_i) * ProdW'(coef_i);
    prod_vld_d = ctrl_i.mul_en;
    acc_d      = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + SumW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= prod_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

FILE: hdl/histogram_fir_smoothing_core.sv
// ----------------------------------------------------------------------------
// Histogram FIR smoothing core
// Centred, zero-padded FIR over a stream of histogram counts, built as a
// circulating chain of cells feeding one multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | sink      | in_valid_i/in_stall_o | func, tap_index, coefficient,
//           |           |                      | sample, last
//   out     | source    | out_valid_o/out_stall_i | smoothed, final_res
//
// Sequence: a coefficient beat is written while idle and does not stall. A
// sample beat that yields a result is shifted in, then the ring of Cells =
// 2*(TAPS/2)+1 cells circulates once past the multiplier, the product register
// drains and the output register is loaded. Each flushed result after the
// last sample repeats this after a zero is shifted in. The ring length sets each pass.
// Reset: asynchronous, active low; clears window, kernel, fill count, FSM.
// Stalls: a finished result waits in the output register while out_stall_i
// is high; the core holds in the load state and stalls the input meanwhile.
// ----------------------------------------------------------------------------
module histogram_fir_smoothing_core
  import hfs_pkg::*;
#(
  parameter int unsigned TAPS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beats
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [IdxW-1:0]    tap_index_i,
  input  logic [CoefW-1:0]   coefficient_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               last_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SumW-1:0]    smoothed_o,
  output logic               final_res_o
);

  localparam int unsigned Half  = TAPS / 2;
  localparam int unsigned Cells = 2 * Half + 1;
  localparam int unsigned RotW  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned FillW = (Half > 0) ? $clog2(Half + 1) : 1;

  // Cell p holds window[2*Half-p] and kernel[p]; cell 0 is the head that
  // feeds the multiplier. Shifting and rotating both move data towards the
  // head, so one full rotation brings every pair past it and back home.

  state_e             state_d, state_q;
  logic [RotW-1:0]    rot_d, rot_q;
  logic [FillW-1:0]   fill_d, fill_q;
  logic [FillW-1:0]   flush_d, flush_q;
  logic               last_d, last_q;

  logic               out_valid_d, out_valid_q;
  logic [SumW-1:0]    smoothed_d, smoothed_q;
  logic               final_d, final_q;

  cell_ctrl_t         cell_ctrl;
  mac_ctrl_t          mac_ctrl;
  logic               in_acc;
  logic               coef_wr;
  logic               out_free;
  logic [SampleW-1:0] shift_data;
  logic [SumW-1:0]    acc;

  logic [SampleW-1:0] win_w  [Cells];
  logic [CoefW-1:0]   coef_w [Cells];

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign coef_wr    = in_acc && (func_i == FuncCoef);
  assign out_free   = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar p = 0; p < Cells; p++) begin : g_cell
    logic [SampleW-1:0] nb_win;
    logic [CoefW-1:0]   nb_coef;
    logic               we;

    if (p == Cells - 1) begin : g_tail
      // tail takes the new count on a shift, the head's pair on a rotation
      assign nb_win  = cell_ctrl.rotate ? win_w[0] : shift_data;
      assign nb_coef = coef_w[0];
    end else begin : g_body
      assign nb_win  = win_w[p+1];
      assign nb_coef = coef_w[p+1];
    end

    if (p < TAPS) begin : g_we
      assign we = coef_wr && (tap_index_i == IdxW'(p));
    end else begin : g_no_we
      // extra slot for an even kernel: its tap stays zero
      assign we = 1'b0;
    end

    hfs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .coef_we_i    (we),
      .coef_wdata_i (coefficient_i),
      .win_i        (nb_win),
      .coef_i       (nb_coef),
      .win_o        (win_w[p]),
      .coef_o       (coef_w[p])
    );
  end

  hfs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .win_i  (win_w[0]),
    .coef_i (coef_w[0]),
    .acc_o  (acc)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    rot_d       = rot_q;
    fill_d      = fill_q;
    flush_d     = flush_q;
    last_d      = last_q;
    cell_ctrl   = '0;
    mac_ctrl    = '0;
    shift_data  = '0;
    out_valid_d = out_valid_q;
    smoothed_d  = smoothed_q;
    final_d     = final_q;

    // drop the held result once it has been taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc && (func_i == FuncSample)) begin
          cell_ctrl.shift = 1'b1;
          shift_data      = sample_i;
          last_d          = last_i;
          if (fill_q == FillW'(Half)) begin
            // window full: this sample yields the value centred Half back
            mac_ctrl.clear = 1'b1;
            rot_d          = '0;
            flush_d        = last_i ? FillW'(Half) : '0;
            state_d        = StRot;
          end else begin
            fill_d = fill_q + 1'b1;
            if (last_i) begin
              // short histogram: flush as many values as bins given
              flush_d = fill_q + 1'b1;
              state_d = StFlush;
            end
          end
        end
      end
      StRot: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.mul_en  = 1'b1;
        rot_d            = rot_q + 1'b1;
        if (rot_q == RotW'(Cells - 1)) begin
          rot_d   = '0;
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last product lands in the accumulator
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          smoothed_d  = acc;
          final_d     = last_q && (flush_q == '0);
          if (flush_q != '0) begin
            state_d = StFlush;
          end else begin
            if (last_q) begin
              cell_ctrl.clear = 1'b1;
              fill_d          = '0;
              last_d          = 1'b0;
            end
            state_d = StIdle;
          end
        end
      end
      StFlush: begin
        // advance a zero into the window and compute the next value
        cell_ctrl.shift = 1'b1;
        shift_data      = '0;
        flush_d         = flush_q - 1'b1;
        mac_ctrl.clear  = 1'b1;
        rot_d           = '0;
        state_d         = StRot;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rot_q       <= '0;
      fill_q      <= '0;
      flush_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rot_q       <= rot_d;
      fill_q      <= fill_d;
      flush_q     <= flush_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smoothed_q <= smoothed_d;
    final_q    <= final_d;
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = smoothed_q;
  assign final_res_o = final_q;

endmodule

FILE: tb/hfs_smoothing_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram FIR smoothing checker
// Watches both channels of the core. Keeps its own window, kernel and fill
// count, predicts every smoothed value and compares each result beat with the
// oldest prediction.
// ----------------------------------------------------------------------------
module hfs_smoothing_checker
  import hfs_pkg::*;
#(
  parameter int unsigned TAPS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               func_i,
  input  logic [IdxW-1:0]    tap_index_i,
  input  logic [CoefW-1:0]   coefficient_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [SumW-1:0]    smoothed_i,
  input  logic               final_res_i,
  output int                 mismatch_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam int unsigned Half = TAPS / 2;
  localparam int unsigned Win  = 2 * Half + 1;

  typedef struct packed {
    logic [SumW-1:0] smoothed;
    logic            final_res;
  } smooth_res_t;

  logic [SampleW-1:0] win_q  [Win];
  logic [CoefW-1:0]   kern_q [TAPS];
  int unsigned        fill_q;
  smooth_res_t        smoothed_due_q [$];
  int                 mismatches;
  int                 checked;

  task automatic shift_count(input logic [SampleW-1:0] v);
    for (int k = Win - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = v;
  endtask

  function automatic logic [SumW-1:0] window_sum();
    logic [63:0] acc;
    logic [63:0] cnt;
    logic [63:0] wgt;
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      cnt = '0;
      wgt = '0;
      cnt[SampleW-1:0] = win_q[2*Half-j];
      wgt[CoefW-1:0]   = kern_q[j];
      acc += cnt * wgt;
    end
    return acc[SumW-1:0];
  endfunction

  task automatic queue_value();
    smooth_res_t r;
    r.smoothed  = window_sum();
    r.final_res = 1'b0;
    smoothed_due_q.push_back(r);
  endtask

  // Predict the smoothed values caused by one accepted input beat
  task automatic smooth_step();
    int unsigned flush;
    int unsigned made;
    made = 0;
    if (func_i == FuncCoef) begin
      if (tap_index_i < TAPS) kern_q[tap_index_i] = coefficient_i;
    end else begin
      shift_count(sample_i);
      if (fill_q >= Half) begin
        queue_value();
        made++;
      end else begin
        fill_q++;
      end
      if (last_i) begin
        flush = fill_q;
        for (int k = 0; k < flush; k++) begin
          shift_count('0);
          queue_value();
          made++;
        end
        if (made > 0) smoothed_due_q[smoothed_due_q.size()-1].final_res = 1'b1;
        for (int k = 0; k < Win; k++) win_q[k] = '0;
        fill_q = 0;
      end
    end
  endtask

  task automatic check_result();
    smooth_res_t want;
    if (smoothed_due_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result beat, smoothed %h final %b", $time,
               smoothed_i, final_res_i);
    end else begin
      want = smoothed_due_q.pop_front();
      checked++;
      if (want.smoothed !== smoothed_i) begin
        mismatches++;
        $display("%0t: smoothed expected %h actual %h", $time, want.smoothed, smoothed_i);
      end
      if (want.final_res !== final_res_i) begin
        mismatches++;
        $display("%0t: final_res expected %b actual %b", $time, want.final_res,
                 final_res_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Win; k++) win_q[k] = '0;
      for (int k = 0; k < TAPS; k++) kern_q[k] = '0;
      fill_q = 0;
      smoothed_due_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (in_valid_i && !in_stall_i) smooth_step();
      if (out_valid_i && !out_stall_i) check_result();
    end
    mismatch_o <= mismatches;
    pending_o  <= smoothed_due_q.size();
    checked_o  <= checked;
  end

endmodule

FILE: tb/histogram_fir_smoothing_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram FIR smoothing core testbench
// Drives kernel writes and histograms into the core under four idling
// regimes; a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module histogram_fir_smoothing_core_test
  import hfs_pkg::*;
;

  localparam int unsigned TAPS     = 31;
  localparam int unsigned RingLat  = 2 * (TAPS / 2) + 1 + 3;
  localparam int          MaxCycle = 1000000;
  localparam int          PhaseBud = 10;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               func_d      = FuncCoef;
  logic [IdxW-1:0]    tap_idx_d   = '0;
  logic [CoefW-1:0]   coef_d      = '0;
  logic [SampleW-1:0] sample_d    = '0;
  logic               last_d      = 1'b0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [SumW-1:0]    smoothed;
  logic               final_res;

  int mismatches;
  int pending;
  int checked;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int beats      = 0;
  int samples    = 0;
  int histograms = 0;
  int cycles     = 0;

  histogram_fir_smoothing_core #(.TAPS(TAPS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func_d),
    .tap_index_i   (tap_idx_d),
    .coefficient_i (coef_d),
    .sample_i      (sample_d),
    .last_i        (last_d),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .smoothed_o    (smoothed),
    .final_res_o   (final_res)
  );

  hfs_smoothing_checker #(.TAPS(TAPS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .func_i        (func_d),
    .tap_index_i   (tap_idx_d),
    .coefficient_i (coef_d),
    .sample_i      (sample_d),
    .last_i        (last_d),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .smoothed_i    (smoothed),
    .final_res_i   (final_res),
    .mismatch_o    (mismatches),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: stall at random at the rate of the current phase
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: fail the run if it is still going when the cycle counter reaches MaxCycle
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MaxCycle) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one beat, with optional idle cycles first, and hold it until taken.
  // The payload stays put while the core stalls.
  task automatic send_beat(input logic fn, input logic [IdxW-1:0] idx,
                           input logic [CoefW-1:0] coef, input logic [SampleW-1:0] smp,
                           input logic lst);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    func_d    <= fn;
    tap_idx_d <= idx;
    coef_d    <= coef;
    sample_d  <= smp;
    last_d    <= lst;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    beats++;
    if (fn == FuncSample) samples++;
    if (fn == FuncSample && lst) histograms++;
  endtask

  // Bin counts: full-range half the time, else zeros, small counts or maxima
  function automatic logic [SampleW-1:0] rand_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SampleW'($urandom_range(0, 1000));
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [CoefW-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CoefW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Send one well-formed histogram, sprinkling kernel writes between bins.
  // Returns the number of beats that the core acts on.
  task automatic send_histogram(input int unsigned len, output int unsigned used);
    logic [IdxW-1:0] idx;
    used = 0;
    for (int unsigned b = 0; b < len; b++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          // out-of-range tap: the core drops it
          idx = IdxW'($urandom_range(TAPS, 126));
        end else begin
          idx = IdxW'($urandom_range(0, TAPS - 1));
          used++;
        end
        send_beat(FuncCoef, idx, rand_weight(), SampleW'($urandom), 1'($urandom));
      end
      send_beat(FuncSample, IdxW'($urandom_range(0, 126)), CoefW'($urandom), rand_count(),
                b == len - 1);
      used++;
    end
  endtask

  initial begin
    int unsigned used;
    int unsigned budget;
    int unsigned len;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ----------------------------------------------------
    // Outer taps at their maximum and the centre at 0x8000; coefficient beats carry
    // sample and last fields that must be ignored.
    send_beat(FuncCoef, 7'd0,  16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(FuncCoef, IdxW'(TAPS - 1), 16'hFFFF, 32'h0, 1'b0);
    send_beat(FuncCoef, IdxW'(TAPS / 2), 16'h8000, 32'h5A5A_5A5A, 1'b1);
    // Tap indices past the kernel: drop
    send_beat(FuncCoef, IdxW'(TAPS), 16'h1234, 32'h0, 1'b0);
    send_beat(FuncCoef, 7'd126, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    // Single-bin histograms, largest and smallest count
    send_beat(FuncSample, 7'd126, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(FuncSample, 7'd0, 16'h0, 32'h0, 1'b1);
    // Histogram shorter than half the kernel
    send_beat(FuncSample, 7'd5, 16'hAAAA, 32'hFFFF_FFFF, 1'b0);
    send_beat(FuncSample, 7'd0, 16'h0, 32'h1, 1'b0);
    send_beat(FuncSample, 7'd0, 16'h0, 32'hFFFF_FFFF, 1'b1);
    // Histogram past the fill point, with a kernel write mid-stream
    for (int b = 0; b < 17; b++) begin
      if (b == 8) send_beat(FuncCoef, 7'd1, 16'hFFFF, 32'h0, 1'b0);
      send_beat(FuncSample, 7'd0, 16'h0, (b % 3 == 1) ? 32'h0 : 32'hFFFF_FFFF, b == 16);
    end

    // --- random part -------------------------------------------------------
    // Load a fresh kernel, then stream histograms under each idling regime.
    for (int t = 0; t < TAPS; t++) begin
      send_beat(FuncCoef, IdxW'(t), rand_weight(), SampleW'($urandom), 1'($urandom));
    end
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      budget = 0;
      while (budget < PhaseBud) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
        send_histogram(len, used);
        budget += used;
      end
    end
    in_valid <= 1'b0;

    // Drain: let the checker register the last beat, wait for the outstanding
    // results, then let the ring idle before the final report
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4 * RingLat) @(posedge clk_i);

    $display("Sent %0d beats: %0d bins in %0d histograms, kernel writes in between.",
             beats, samples, histograms);
    $display("Checked %0d smoothed values across four idling regimes.", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
